/* hw/rtl/brhp_pkg.sv */
`default_nettype none

package brhp_pkg;

    // widths fixed by the stream fields
    localparam int CHAR_W        = 8;
    localparam int FIELD_W       = 48;
    localparam int SIZE_BITS_DEF = 48;

    // bytes of the "bytes=" lead text
    localparam logic [2:0] PREFIX_LEN = 3'd6;

    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;

    typedef enum logic [2:0] {
        PH_PREFIX,
        PH_FIRST,
        PH_SECOND,
        PH_CLOSED,
        PH_REJECT
    } phase_t;

    typedef struct packed {
        logic second_bad;
        logic second_any;
        logic first_bad;
        logic first_any;
    } flags_t;

    // parser status handed to the range evaluation
    typedef struct packed {
        phase_t phase;
        flags_t flags;
    } parse_stat_t;

    function automatic logic [CHAR_W-1:0] lead_char(input logic [2:0] pos);
        logic [CHAR_W-1:0] c;
        case (pos)
            3'd0:    c = 8'h62; // b
            3'd1:    c = 8'h79; // y
            3'd2:    c = 8'h74; // t
            3'd3:    c = 8'h65; // e
            3'd4:    c = 8'h73; // s
            3'd5:    c = 8'h3D; // =
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/brhp_parse.sv */
`default_nettype none

module brhp_parse #(
    parameter int SIZE_BITS = brhp_pkg::SIZE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic                          has_char,
    input  logic                          last,
    input  logic [brhp_pkg::CHAR_W-1:0]   hdr_char,
    output brhp_pkg::parse_stat_t         snap_stat,
    output logic [SIZE_BITS-1:0]          snap_first,
    output logic [SIZE_BITS-1:0]          snap_second
);
    import brhp_pkg::*;

    localparam int EXT_W = SIZE_BITS + 4;

    phase_t               phase_reg, phase_upd, phase_next;
    logic [2:0]           pos_reg, pos_upd, pos_next;
    logic [SIZE_BITS-1:0] first_reg, first_upd, first_next;
    logic [SIZE_BITS-1:0] second_reg, second_upd, second_next;
    flags_t               flags_reg, flags_upd, flags_next;

    logic                 is_digit;
    logic [3:0]           digit;
    logic [SIZE_BITS-1:0] dig_base;
    logic [EXT_W-1:0]     dig_ext;
    logic [EXT_W-1:0]     dig_prod;
    logic [SIZE_BITS-1:0] dig_val;

    // one shared times-ten-plus-digit, saturating
    assign is_digit = (hdr_char >= CH_0) && (hdr_char <= CH_9);
    assign digit    = 4'(hdr_char - CH_0);
    assign dig_base = (phase_reg == PH_FIRST) ? first_reg : second_reg;
    assign dig_ext  = EXT_W'(dig_base);
    assign dig_prod = (dig_ext << 3) + (dig_ext << 1) + EXT_W'(digit);
    assign dig_val  = (|dig_prod[EXT_W-1:SIZE_BITS]) ? '1 : dig_prod[SIZE_BITS-1:0];

    always_comb begin
        phase_upd  = phase_reg;
        pos_upd    = pos_reg;
        first_upd  = first_reg;
        second_upd = second_reg;
        flags_upd  = flags_reg;
        if (has_char) begin
            case (phase_reg)
                PH_PREFIX: begin
                    if (hdr_char == lead_char(pos_reg)) begin
                        pos_upd = pos_reg + 3'd1;
                        if (pos_upd == PREFIX_LEN) begin
                            phase_upd = PH_FIRST;
                        end
                    end else begin
                        phase_upd = PH_REJECT;
                    end
                end
                PH_FIRST: begin
                    if (hdr_char == CH_COMMA) begin
                        phase_upd = PH_REJECT;
                    end else if (hdr_char == CH_DASH) begin
                        phase_upd = PH_SECOND;
                    end else begin
                        flags_upd.first_any = 1'b1;
                        if (is_digit) begin
                            first_upd = dig_val;
                        end else begin
                            flags_upd.first_bad = 1'b1;
                        end
                    end
                end
                PH_SECOND: begin
                    if (hdr_char == CH_COMMA) begin
                        phase_upd = PH_CLOSED;
                    end else begin
                        flags_upd.second_any = 1'b1;
                        if (is_digit) begin
                            second_upd = dig_val;
                        end else begin
                            flags_upd.second_bad = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // a last item hands its status on and starts a fresh header
    always_comb begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        first_next  = first_reg;
        second_next = second_reg;
        flags_next  = flags_reg;
        if (step) begin
            if (last) begin
                phase_next  = PH_PREFIX;
                pos_next    = '0;
                first_next  = '0;
                second_next = '0;
                flags_next  = '0;
            end else begin
                phase_next  = phase_upd;
                pos_next    = pos_upd;
                first_next  = first_upd;
                second_next = second_upd;
                flags_next  = flags_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_PREFIX;
            pos_reg    <= '0;
            first_reg  <= '0;
            second_reg <= '0;
            flags_reg  <= '0;
        end else begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            flags_reg  <= flags_next;
        end
    end

    assign snap_stat.phase = phase_upd;
    assign snap_stat.flags = flags_upd;
    assign snap_first      = first_upd;
    assign snap_second     = second_upd;

endmodule

`default_nettype wire

/* hw/rtl/brhp_eval.sv */
`default_nettype none

module brhp_eval #(
    parameter int SIZE_BITS = brhp_pkg::SIZE_BITS_DEF
) (
    input  brhp_pkg::parse_stat_t stat,
    input  logic [SIZE_BITS-1:0]  first_num,
    input  logic [SIZE_BITS-1:0]  second_num,
    input  logic [SIZE_BITS-1:0]  size,
    output logic                  present,
    output logic                  satisfiable,
    output logic [SIZE_BITS-1:0]  range_begin,
    output logic [SIZE_BITS-1:0]  range_end
);
    import brhp_pkg::*;

    logic                 size_nz;
    logic [SIZE_BITS-1:0] size_m1;
    logic                 second_lt_size;
    logic                 first_lt_size;
    logic                 first_le_second;
    logic                 sat_suffix, sat_start, sat_any;
    logic [SIZE_BITS-1:0] begin_suffix, end_start;

    assign size_nz         = (size != '0);
    assign size_m1         = size - SIZE_BITS'(1);
    assign second_lt_size  = (second_num < size);
    assign first_lt_size   = (first_num < size);
    assign first_le_second = (first_num <= second_num);

    assign present = size_nz && (stat.phase == PH_SECOND || stat.phase == PH_CLOSED);

    // suffix form: last n bytes
    assign sat_suffix   = stat.flags.second_any && !stat.flags.second_bad && (second_num != '0);
    assign begin_suffix = second_lt_size ? (size - second_num) : '0;

    // start form: begin is within the content and not past the given end
    assign sat_start = !stat.flags.first_bad
                     && !(stat.flags.second_any && stat.flags.second_bad)
                     && first_lt_size
                     && (!stat.flags.second_any || first_le_second);
    assign end_start = (stat.flags.second_any && second_lt_size) ? second_num : size_m1;

    assign sat_any = stat.flags.first_any ? sat_start : sat_suffix;

    always_comb begin
        satisfiable = 1'b1;
        range_begin = '0;
        range_end   = '0;
        if (present) begin
            satisfiable = sat_any;
            if (sat_any) begin
                range_begin = stat.flags.first_any ? first_num : begin_suffix;
                range_end   = stat.flags.first_any ? end_start : size_m1;
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/byte_range_header_parser.sv */
// byte range header parser
//
// input stream: one transaction per header byte. s_tdata[7:0] is the byte,
// s_tdata[55:8] the content size (only looked at on the last transaction),
// s_tuser says the byte is real, s_tlast closes the header. a missing header
// is sent as a single transaction with s_tuser low and s_tlast high.
// output stream: one transaction per header. m_tuser[0] says a range is
// present, m_tuser[1] that it is satisfiable (low means status 416);
// m_tdata holds the inclusive begin and end offsets, zero unless the range
// is both present and satisfiable.
// throughput: one transaction per cycle while s_tready is high; the parser
// state is updated from each registered byte.
// result path: a last transaction passes the input register, the evaluation
// register and the output register before it shows on m_tvalid; each step
// may wait on the stall below.
// reset: aresetn low clears all valid flags and the parser state.
// stall: while m_tready is low the result is held; non-last bytes keep
// flowing, and s_tready drops only while a last transaction waits behind full
// evaluation and output registers
`default_nettype none

module byte_range_header_parser #(
    parameter int SIZE_BITS = brhp_pkg::SIZE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // header_char [7:0], content_len [55:8]
    input  logic        s_tuser,  // has_char
    input  logic        s_tlast,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,  // range_begin [47:0], range_end [95:48]
    output logic [1:0]  m_tuser   // range_present [0], range_satisfiable [1]
);
    import brhp_pkg::*;

    // input register
    logic                    in_valid_reg, in_valid_next;
    logic [CHAR_W-1:0]       in_char_reg;
    logic                    in_has_reg;
    logic                    in_last_reg;
    logic [FIELD_W-1:0]      in_size_reg;

    // evaluation register, loaded by a last transaction
    logic                    ev_valid_reg, ev_valid_next;
    parse_stat_t             ev_stat_reg;
    logic [SIZE_BITS-1:0]    ev_first_reg;
    logic [SIZE_BITS-1:0]    ev_second_reg;
    logic [SIZE_BITS-1:0]    ev_size_reg;

    // output register
    logic                    out_valid_reg, out_valid_next;
    logic                    out_present_reg;
    logic                    out_sat_reg;
    logic [FIELD_W-1:0]      out_begin_reg;
    logic [FIELD_W-1:0]      out_end_reg;

    logic                    in_take;
    logic                    in_consume;
    logic                    ev_ready;
    logic                    ev_load;
    logic                    ev_move;
    logic                    out_ready;

    parse_stat_t             snap_stat;
    logic [SIZE_BITS-1:0]    snap_first;
    logic [SIZE_BITS-1:0]    snap_second;

    logic                    res_present;
    logic                    res_sat;
    logic [SIZE_BITS-1:0]    res_begin;
    logic [SIZE_BITS-1:0]    res_end;

    // flow control: a non-last byte always moves on, a last byte needs room
    // in the evaluation register
    assign out_ready  = !out_valid_reg || m_tready;
    assign ev_move    = ev_valid_reg && out_ready;
    assign ev_ready   = !ev_valid_reg || out_ready;
    assign in_consume = in_valid_reg && (!in_last_reg || ev_ready);
    assign ev_load    = in_consume && in_last_reg;
    assign s_tready   = !in_valid_reg || in_consume;
    assign in_take    = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_take) begin
            in_valid_next = 1'b1;
        end else if (in_consume) begin
            in_valid_next = 1'b0;
        end
        ev_valid_next = ev_valid_reg;
        if (ev_load) begin
            ev_valid_next = 1'b1;
        end else if (ev_move) begin
            ev_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (ev_move) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            ev_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            ev_valid_reg  <= ev_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_char_reg <= s_tdata[7:0];
            in_size_reg <= s_tdata[55:8];
            in_has_reg  <= s_tuser;
            in_last_reg <= s_tlast;
        end
        if (ev_load) begin
            ev_stat_reg   <= snap_stat;
            ev_first_reg  <= snap_first;
            ev_second_reg <= snap_second;
            ev_size_reg   <= SIZE_BITS'(in_size_reg);
        end
        if (ev_move) begin
            out_present_reg <= res_present;
            out_sat_reg     <= res_sat;
            out_begin_reg   <= FIELD_W'(res_begin);
            out_end_reg     <= FIELD_W'(res_end);
        end
    end

    brhp_parse #(
        .SIZE_BITS (SIZE_BITS)
    ) u_parse (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (in_consume),
        .has_char    (in_has_reg),
        .last        (in_last_reg),
        .hdr_char    (in_char_reg),
        .snap_stat   (snap_stat),
        .snap_first  (snap_first),
        .snap_second (snap_second)
    );

    brhp_eval #(
        .SIZE_BITS (SIZE_BITS)
    ) u_eval (
        .stat        (ev_stat_reg),
        .first_num   (ev_first_reg),
        .second_num  (ev_second_reg),
        .size        (ev_size_reg),
        .present     (res_present),
        .satisfiable (res_sat),
        .range_begin (res_begin),
        .range_end   (res_end)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_end_reg, out_begin_reg};
    assign m_tuser  = {out_sat_reg, out_present_reg};

endmodule

`default_nettype wire

/* hw/rtl/brhp_checker.sv */
`default_nettype none

module brhp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // no range means satisfiable with zero offsets
    a_absent_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tuser[1] && (m_tdata == '0))
        else $error("absent range with nonzero result");

    // unsatisfiable range carries zero offsets
    a_unsat_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[1] |-> (m_tdata == '0))
        else $error("unsatisfiable range with nonzero offsets");

    // a satisfiable range never runs backwards
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] && m_tuser[1] |-> (m_tdata[47:0] <= m_tdata[95:48]))
        else $error("range begin past range end");

    // nothing offered right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered after reset");

endmodule

bind byte_range_header_parser brhp_checker u_brhp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

/* tb/testbench.sv */
`default_nettype none

module testbench;
    import brhp_pkg::*;

    localparam int          N_ITEMS    = 1300;
    localparam int          IDLE_LIMIT = 2000;
    localparam int          N_ROWS     = 24;
    localparam logic [47:0] NUM_MAX    = 48'hFFFF_FFFF_FFFF;
    localparam logic [47:0] LEAD       = "bytes=";

    // one result transaction as the parser reports it
    typedef struct packed {
        logic        present;
        logic        sat;
        logic [47:0] rbeg;
        logic [47:0] rend;
    } range_res_t;

    // one input transaction
    typedef struct packed {
        logic [7:0]  ch;
        logic        has;
        logic        lst;
        logic [47:0] csize;
    } hdr_item_t;

    // directed row: header text right-aligned, a zero text is an absent header
    typedef struct packed {
        logic [255:0] txt;
        logic [47:0]  csize;
        logic         holes;
        logic         tail;
        logic         lit;
        range_res_t   want;
    } dir_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;  // header_char [7:0], content_len [55:8]
    logic        s_tuser;  // has_char
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;  // range_begin [47:0], range_end [95:48]
    logic [1:0]  m_tuser;  // range_present [0], range_satisfiable [1]

    byte_range_header_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // parser shadow state
    phase_t      hp_phase;
    logic [2:0]  hp_pos;
    logic [47:0] hp_first;
    logic [47:0] hp_second;
    flags_t      hp_flags;

    range_res_t  pending_ranges[$];
    hdr_item_t   hdr_q[$];
    dir_row_t    dir_rows[N_ROWS];

    bit          lit_on;
    range_res_t  lit_res;
    bit          burst;
    int          hole_pct;

    int n_items, n_headers, n_checked, n_present, n_sat, n_fail;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic logic [47:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[47:0];
    endfunction

    function automatic logic [47:0] append_digit(input logic [47:0] n, input logic [3:0] d);
        logic [63:0] lim;
        logic [63:0] prod;
        lim  = ({16'd0, NUM_MAX} - 64'(d)) / 64'd10;
        prod = {16'd0, n} * 64'd10 + 64'(d);
        if ({16'd0, n} > lim) return NUM_MAX;
        return prod[47:0];
    endfunction

    task automatic parser_reset();
        hp_phase  = PH_PREFIX;
        hp_pos    = 3'd0;
        hp_first  = 48'd0;
        hp_second = 48'd0;
        hp_flags  = '0;
    endtask

    task automatic parser_take(input logic [7:0] c);
        logic dig;
        dig = (c >= CH_0) && (c <= CH_9);
        case (hp_phase)
            PH_PREFIX: begin
                if (hp_pos < PREFIX_LEN && c == LEAD[8*(5-int'(hp_pos)) +: 8]) begin
                    hp_pos = hp_pos + 3'd1;
                    if (hp_pos == PREFIX_LEN) hp_phase = PH_FIRST;
                end else begin
                    hp_phase = PH_REJECT;
                end
            end
            PH_FIRST: begin
                if (c == CH_COMMA) begin
                    hp_phase = PH_REJECT;
                end else if (c == CH_DASH) begin
                    hp_phase = PH_SECOND;
                end else begin
                    hp_flags.first_any = 1'b1;
                    if (dig) hp_first = append_digit(hp_first, c[3:0]);
                    else hp_flags.first_bad = 1'b1;
                end
            end
            PH_SECOND: begin
                if (c == CH_COMMA) begin
                    hp_phase = PH_CLOSED;
                end else begin
                    hp_flags.second_any = 1'b1;
                    if (dig) hp_second = append_digit(hp_second, c[3:0]);
                    else hp_flags.second_bad = 1'b1;
                end
            end
            default: ;
        endcase
    endtask

    function automatic range_res_t range_eval(input logic [47:0] sz);
        range_res_t r;
        r.present = 1'b0;
        r.sat     = 1'b1;
        r.rbeg    = 48'd0;
        r.rend    = 48'd0;
        if (sz != 48'd0 && (hp_phase == PH_SECOND || hp_phase == PH_CLOSED)) begin
            r.present = 1'b1;
            if (!hp_flags.first_any) begin
                // suffix form
                if (!hp_flags.second_any || hp_flags.second_bad || hp_second == 48'd0) begin
                    r.sat = 1'b0;
                end else begin
                    r.rbeg = (hp_second < sz) ? sz - hp_second : 48'd0;
                    r.rend = sz - 48'd1;
                end
            end else if (hp_flags.first_bad) begin
                r.sat = 1'b0;
            end else if (hp_flags.second_any && hp_flags.second_bad) begin
                r.sat = 1'b0;
            end else begin
                r.rend = hp_flags.second_any ? hp_second : sz - 48'd1;
                if (r.rend > sz - 48'd1) r.rend = sz - 48'd1;
                r.rbeg = hp_first;
            end
            if (r.sat && (r.rbeg > r.rend || r.rbeg >= sz)) r.sat = 1'b0;
            if (!r.sat) begin
                r.rbeg = 48'd0;
                r.rend = 48'd0;
            end
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [47:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 48'd0;
        if (r < 55) return 48'($urandom_range(1, 400));
        if (r < 70) return 48'($urandom_range(1, 65535));
        if (r < 88) return rand48() >> $urandom_range(0, 40);
        if (r < 94) return NUM_MAX;
        return rand48();
    endfunction

    function automatic logic [7:0] non_digit();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c >= CH_0 && c <= CH_9);
        return c;
    endfunction

    function automatic logic [7:0] noise_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return CH_0 + 8'($urandom_range(0, 9));
        if (r < 45) return CH_DASH;
        if (r < 55) return CH_COMMA;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic put_hole();
        hdr_q.insert(hdr_q.size(),
                     hdr_item_t'{8'($urandom_range(0, 255)), 1'b0, 1'b0, rand48()});
    endtask

    task automatic put_char(input logic [7:0] c);
        if (hole_pct != 0 && $urandom_range(0, 99) < hole_pct) put_hole();
        hdr_q.insert(hdr_q.size(), hdr_item_t'{c, 1'b1, 1'b0, rand48()});
    endtask

    task automatic finish_header(input logic [47:0] sz, input bit tail);
        if (tail || hdr_q.size() == 0) begin
            hdr_q.insert(hdr_q.size(),
                         hdr_item_t'{8'($urandom_range(0, 255)), 1'b0, 1'b1, sz});
        end else begin
            hdr_q[hdr_q.size()-1].lst   = 1'b1;
            hdr_q[hdr_q.size()-1].csize = sz;
        end
    endtask

    // decimal text of a number, with a mix of magnitudes around the size
    task automatic put_number(input logic [47:0] sz);
        logic [63:0] v;
        logic [7:0]  dq[$];
        int          r, n;
        r = $urandom_range(0, 99);
        if (r >= 90) begin
            // fifteen digits or more, mostly past the saturation point
            put_char(CH_0 + 8'($urandom_range(1, 9)));
            n = $urandom_range(14, 22);
            repeat (n) put_char(CH_0 + 8'($urandom_range(0, 9)));
        end else begin
            if (r < 35) v = 64'($urandom_range(0, 400));
            else if (r < 55) v = ({16'd0, sz} >= 64'd2) ? {16'd0, sz} - 64'd2 +
                                 64'($urandom_range(0, 4)) : 64'($urandom_range(0, 3));
            else if (r < 75) v = {16'd0, rand48() >> $urandom_range(0, 47)};
            else if (r < 83) v = {16'd0, NUM_MAX} - 64'($urandom_range(0, 10));
            else begin
                n = $urandom_range(1, 3);
                repeat (n) put_char(CH_0);
                v = 64'($urandom_range(0, 400));
            end
            if (v == 64'd0) dq.push_front(CH_0);
            while (v != 64'd0) begin
                dq.push_front(CH_0 + 8'(v % 64'd10));
                v = v / 64'd10;
            end
            foreach (dq[i]) put_char(dq[i]);
        end
    endtask

    task automatic make_random_header();
        logic [47:0] sz;
        int          k, n;
        logic [7:0]  c;
        hole_pct = ($urandom_range(0, 99) < 15) ? 20 : 0;
        sz = pick_size();
        if ($urandom_range(0, 99) < 80) begin
            k = $urandom_range(0, 99);
            for (n = 0; n < 6; n++) begin
                c = LEAD[8*(5-n) +: 8];
                if (n == k) c = 8'($urandom_range(0, 255));
                put_char(c);
            end
            if ($urandom_range(0, 99) < 75) put_number(sz);
            if ($urandom_range(0, 99) < 5) put_char(non_digit());
            if ($urandom_range(0, 99) < 4) put_char(CH_COMMA);
            if ($urandom_range(0, 99) < 95) put_char(CH_DASH);
            if ($urandom_range(0, 99) < 65) put_number(sz);
            if ($urandom_range(0, 99) < 4) put_char(CH_DASH);
            if ($urandom_range(0, 99) < 5) put_char(non_digit());
            if ($urandom_range(0, 99) < 12) begin
                put_char(CH_COMMA);
                n = $urandom_range(0, 6);
                repeat (n) put_char(noise_char());
            end
        end else begin
            // noise, sometimes behind a good prefix
            if ($urandom_range(0, 1) == 1) begin
                for (n = 0; n < 6; n++) put_char(LEAD[8*(5-n) +: 8]);
            end
            n = $urandom_range(0, 10);
            repeat (n) put_char(noise_char());
        end
        finish_header(sz, $urandom_range(0, 99) < 10);
    endtask

    // one transaction on the input side, entered and left at a falling edge
    task automatic send_item(input hdr_item_t it);
        int         gap;
        range_res_t res;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {it.csize, it.ch};
        s_tuser  <= it.has;
        s_tlast  <= it.lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n_items++;
        if (it.has) parser_take(it.ch);
        if (it.lst) begin
            res = lit_on ? lit_res : range_eval(it.csize);
            parser_reset();
            pending_ranges.insert(pending_ranges.size(), res);
            n_headers++;
        end
        @(negedge aclk);
    endtask

    task automatic ship_header();
        foreach (hdr_q[i]) send_item(hdr_q[i]);
        hdr_q.delete();
    endtask

    // sender holds off until every result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_ranges.size() != 0);
    endtask

    // result side back-pressure
    initial begin
        int run, r;
        bit v;
        m_tready = 1'b0;
        forever begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                v = 1'b1;
                run = $urandom_range(1, 12);
            end else if (r < 85) begin
                v = 1'b0;
                run = $urandom_range(1, 3);
            end else if (r < 95) begin
                v = 1'b1;
                run = $urandom_range(50, 200);
            end else begin
                v = 1'b0;
                run = $urandom_range(10, 50);
            end
            repeat (run) begin
                @(negedge aclk);
                m_tready <= v;
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        range_res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.present = m_tuser[0];
            got.sat     = m_tuser[1];
            got.rbeg    = m_tdata[47:0];
            got.rend    = m_tdata[95:48];
            if (pending_ranges.size() == 0) begin
                $error("result transaction with nothing expected");
                n_fail++;
            end else begin
                want = pending_ranges.pop_front();
                n_checked++;
                if (want.present) n_present++;
                if (want.present && want.sat) n_sat++;
                if (got.present !== want.present) begin
                    $error("range_present: expected %0d, actual %0d", want.present, got.present);
                    n_fail++;
                end
                if (got.sat !== want.sat) begin
                    $error("range_satisfiable: expected %0d, actual %0d", want.sat, got.sat);
                    n_fail++;
                end
                if (got.rbeg !== want.rbeg) begin
                    $error("range_begin: expected %0d, actual %0d", want.rbeg, got.rbeg);
                    n_fail++;
                end
                if (got.rend !== want.rend) begin
                    $error("range_end: expected %0d, actual %0d", want.rend, got.rend);
                    n_fail++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
            else idle++;
        end
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, pending_ranges.size());
        $display("FAIL byte_range_header_parser");
        $finish;
    end

    initial begin
        int         i, k;
        logic [7:0] c;
        bit         started;

        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        s_tlast  = 1'b0;
        aresetn  = 1'b0;
        lit_on   = 1'b0;
        lit_res  = '0;
        burst    = 1'b0;
        hole_pct = 0;
        n_items = 0; n_headers = 0; n_checked = 0;
        n_present = 0; n_sat = 0; n_fail = 0;
        parser_reset();

        //             text                              size                  holes tail lit
        dir_rows[0]  = '{256'd0, 48'd100, 1'b0, 1'b0, 1'b1,
                         '{1'b0, 1'b1, 48'd0, 48'd0}};   // header absent
        dir_rows[1]  = '{"bytes=0-99", 48'd100, 1'b0, 1'b0, 1'b1,
                         '{1'b1, 1'b1, 48'd0, 48'd99}};
        dir_rows[2]  = '{"bytes=0-", 48'd0, 1'b0, 1'b0, 1'b1,
                         '{1'b0, 1'b1, 48'd0, 48'd0}};   // empty content
        dir_rows[3]  = '{"bytes=-50", 48'd100, 1'b0, 1'b0, 1'b1,
                         '{1'b1, 1'b1, 48'd50, 48'd99}};
        dir_rows[4]  = '{"bytes=-500", 48'd100, 1'b0, 1'b0, 1'b1,
                         '{1'b1, 1'b1, 48'd0, 48'd99}};
        dir_rows[5]  = '{"bytes=-0", 48'd100, 1'b0, 1'b0, 1'b1,
                         '{1'b1, 1'b0, 48'd0, 48'd0}};
        dir_rows[6]  = '{"bytes=-", 48'd100, 1'b0, 1'b0, 1'b1,
                         '{1'b1, 1'b0, 48'd0, 48'd0}};
        dir_rows[7]  = '{"bytes=100-", 48'd100, 1'b0, 1'b0, 1'b1,
                         '{1'b1, 1'b0, 48'd0, 48'd0}};
        dir_rows[8]  = '{"bytes=5-2", 48'd100, 1'b0, 1'b0, 1'b1,
                         '{1'b1, 1'b0, 48'd0, 48'd0}};
        dir_rows[9]  = '{"bytes=10-999999", 48'd100, 1'b0, 1'b0, 1'b1,
                         '{1'b1, 1'b1, 48'd10, 48'd99}};
        dir_rows[10] = '{"bytes=99999999999999999999-", NUM_MAX, 1'b0, 1'b0, 1'b0, '0};
        dir_rows[11] = '{"bytes=0-99999999999999999999", NUM_MAX, 1'b0, 1'b0, 1'b1,
                         '{1'b1, 1'b1, 48'd0, 48'hFFFF_FFFF_FFFE}};
        dir_rows[12] = '{"bytes=1-2-3", 48'd100, 1'b0, 1'b0, 1'b1,
                         '{1'b1, 1'b0, 48'd0, 48'd0}};   // second dash
        dir_rows[13] = '{"bytes=1-5,7-9", 48'd100, 1'b0, 1'b0, 1'b1,
                         '{1'b1, 1'b1, 48'd1, 48'd5}};   // later ranges ignored
        dir_rows[14] = '{"bytes=,0-5", 48'd100, 1'b0, 1'b0, 1'b1,
                         '{1'b0, 1'b1, 48'd0, 48'd0}};   // comma before dash
        dir_rows[15] = '{"bytes=0", 48'd100, 1'b0, 1'b0, 1'b1,
                         '{1'b0, 1'b1, 48'd0, 48'd0}};
        dir_rows[16] = '{"byte=0-5", 48'd100, 1'b0, 1'b0, 1'b1,
                         '{1'b0, 1'b1, 48'd0, 48'd0}};   // prefix mismatch
        dir_rows[17] = '{"bytes=a-5", 48'd100, 1'b0, 1'b0, 1'b1,
                         '{1'b1, 1'b0, 48'd0, 48'd0}};
        dir_rows[18] = '{"bytes=-5x", 48'd100, 1'b0, 1'b0, 1'b1,
                         '{1'b1, 1'b0, 48'd0, 48'd0}};
        dir_rows[19] = '{"bytes=3-7", 48'd100, 1'b1, 1'b0, 1'b0, '0};   // empty items between
        dir_rows[20] = '{"bytes=2-", 48'd50, 1'b0, 1'b1, 1'b0, '0};     // empty last item
        dir_rows[21] = '{"bytes=0-0", 48'd1, 1'b0, 1'b0, 1'b1,
                         '{1'b1, 1'b1, 48'd0, 48'd0}};
        dir_rows[22] = '{"bytes=-281474976710655", NUM_MAX, 1'b0, 1'b0, 1'b0, '0};
        dir_rows[23] = '{"Bytes=0-1", 48'd10, 1'b0, 1'b0, 1'b0, '0};

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed rows
        for (i = 0; i < N_ROWS; i++) begin
            lit_on   = dir_rows[i].lit;
            lit_res  = dir_rows[i].want;
            hole_pct = dir_rows[i].holes ? 100 : 0;
            started  = 1'b0;
            for (k = 31; k >= 0; k--) begin
                c = dir_rows[i].txt[8*k +: 8];
                if (c != 8'd0) started = 1'b1;
                if (started) put_char(c);
            end
            finish_header(dir_rows[i].csize, dir_rows[i].tail);
            ship_header();
        end
        lit_on   = 1'b0;
        hole_pct = 0;
        drain();

        // random headers
        while (n_items < N_ITEMS) begin
            burst = ($urandom_range(0, 99) < 15);
            if ($urandom_range(0, 49) == 0) drain();
            make_random_header();
            ship_header();
        end
        drain();
        repeat (10) @(posedge aclk);

        $display("covered %0d headers over %0d input transactions, %0d results checked",
                 n_headers, n_items, n_checked);
        $display("of those %0d carried a range and %0d were satisfiable", n_present, n_sat);
        if (n_fail == 0 && pending_ranges.size() == 0) begin
            $display("PASS byte_range_header_parser");
        end else begin
            $display("FAIL byte_range_header_parser");
        end
        $finish;
    end

endmodule

`default_nettype wire
